// ===== src/pmau_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package pmau_pkg;
    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_NOT_PRESENT = 2'd1;
    localparam logic [1:0] ST_RANGE       = 2'd2;

    localparam logic       CFG_PAGING_ENABLE = 1'b0;
    localparam logic       CFG_PAGE_DIR_BASE = 1'b1;

    localparam int BIT_PRESENT  = 0;
    localparam int BIT_ACCESSED = 5;
    localparam int BIT_DIRTY    = 6;

    // datapath operation selects
    typedef enum logic [2:0] {
        t_OP_NONE,
        t_OP_START,
        t_OP_READ_BYTE,
        t_OP_WRITE_BYTE,
        t_OP_LOAD_DE,
        t_OP_LOAD_TE,
        t_OP_NEXT_PART
    } t_op;

    // address source for byte accesses
    typedef enum logic [1:0] {
        t_SRC_DE,
        t_SRC_TE,
        t_SRC_DATA
    } t_src;

    typedef struct packed {
        t_op        op;
        t_src       src;
        logic [1:0] idx;
        logic       set_te_dirty;
    } t_cmd;

    typedef struct packed {
        logic       paging;
        logic       wr;
        logic       split;
        logic       second;
        logic [2:0] len;
        logic       de_fits;
        logic       te_fits;
        logic       data_fits;
        logic       de_present;
        logic       de_need_wb;
        logic       te_present;
        logic       te_need_wb;
    } t_status;
endpackage
`default_nettype wire

// ===== src/pmau_stream_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface pmau_stream_if #(
    parameter int WIDTH = 8
);
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== src/pmau_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
module pmau_datapath #(
    parameter int PHYS_MEM_BYTES = 65536
) (
    input  wire                 i_clk,
    input  wire                 i_paging,
    input  wire [19:0]          i_pdb,
    input  wire                 i_in_wr,
    input  wire [31:0]          i_in_va,
    input  wire [2:0]           i_in_len,
    input  wire [31:0]          i_in_wdata,
    input  wire pmau_pkg::t_cmd i_cmd,
    input  wire                 i_rd_valid,
    output pmau_pkg::t_status   o_status,
    output logic [31:0]         o_rdata
);
    import pmau_pkg::*;

    localparam int AW = $clog2(PHYS_MEM_BYTES);

    logic [7:0]  r_mem [PHYS_MEM_BYTES];
    logic [7:0]  r_q;
    logic        r_wr, r_second, r_split;
    logic [31:0] r_va, r_wdata, r_de, r_te, r_rdata;
    logic [2:0]  r_len, r_len_total, r_left;
    logic [1:0]  r_rd_idx;
    logic [1:0]  r_rd_src;

    logic [31:0] w_de_addr, w_te_addr, w_pa, w_addr;
    logic [32:0] w_data_end;
    logic [7:0]  w_wbyte;
    logic [12:0] w_room;
    logic [2:0]  w_len_sat;

    assign w_de_addr = {i_pdb, 12'd0} + {20'd0, r_va[31:22], 2'd0};
    assign w_te_addr = {r_de[31:12], 12'd0} + {20'd0, r_va[21:12], 2'd0};
    assign w_pa      = i_paging ? {r_te[31:12], r_va[11:0]} : r_va;
    assign w_data_end = {1'b0, w_pa} + {30'd0, r_len};

    // byte address select
    always_comb begin
        unique case (i_cmd.src)
            t_SRC_DE: w_addr = w_de_addr + {30'd0, i_cmd.idx};
            t_SRC_TE: w_addr = w_te_addr + {30'd0, i_cmd.idx};
            default:  w_addr = w_pa + {30'd0, i_cmd.idx};
        endcase
    end

    // byte to store
    always_comb begin
        unique case (i_cmd.src)
            t_SRC_DE: w_wbyte = r_de[8*i_cmd.idx +: 8] | (i_cmd.idx == 2'd0 ? 8'h20 : 8'h00);
            t_SRC_TE: w_wbyte = r_te[8*i_cmd.idx +: 8]
                | (i_cmd.idx == 2'd0 ? (i_cmd.set_te_dirty ? 8'h60 : 8'h20) : 8'h00);
            default:  w_wbyte = r_wdata[8*i_cmd.idx +: 8];
        endcase
    end

    assign w_len_sat = (i_in_len > 3'd4) ? 3'd4 : i_in_len;
    assign w_room    = 13'd4096 - {1'b0, i_in_va[11:0]};

    // memory port
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == t_OP_WRITE_BYTE)
            r_mem[w_addr[AW-1:0]] <= w_wbyte;
        r_q      <= r_mem[w_addr[AW-1:0]];
        r_rd_idx <= i_cmd.idx;
        r_rd_src <= i_cmd.src;
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_rd_valid) begin
            unique case (t_src'(r_rd_src))
                t_SRC_DE: r_de[8*r_rd_idx +: 8] <= r_q;
                t_SRC_TE: r_te[8*r_rd_idx +: 8] <= r_q;
                default: begin
                    if (r_second)
                        r_rdata[8*(r_rd_idx + r_left[1:0]) +: 8] <= r_q;
                    else
                        r_rdata[8*r_rd_idx +: 8] <= r_q;
                end
            endcase
        end
        unique case (i_cmd.op)
            t_OP_START: begin
                r_wr        <= i_in_wr;
                r_va        <= i_in_va;
                r_wdata     <= i_in_wdata;
                r_rdata     <= 32'd0;
                r_second    <= 1'b0;
                r_len_total <= w_len_sat;
                if (i_paging && {10'd0, w_len_sat} > w_room) begin
                    r_split <= 1'b1;
                    r_len   <= w_room[2:0];
                    r_left  <= w_room[2:0];
                end else begin
                    r_split <= 1'b0;
                    r_len   <= w_len_sat;
                    r_left  <= 3'd0;
                end
            end
            t_OP_NEXT_PART: begin
                r_second <= 1'b1;
                r_va     <= r_va + {29'd0, r_left};
                r_len    <= r_len_total - r_left;
                r_wdata  <= r_wdata >> (8 * r_left);
            end
            default: ;
        endcase
    end

    assign o_status.paging     = i_paging;
    assign o_status.wr         = r_wr;
    assign o_status.split      = r_split;
    assign o_status.second     = r_second;
    assign o_status.len        = r_len;
    assign o_status.de_fits    = {1'b0, w_de_addr} + 33'd4 <= 33'(PHYS_MEM_BYTES);
    assign o_status.te_fits    = {1'b0, w_te_addr} + 33'd4 <= 33'(PHYS_MEM_BYTES);
    assign o_status.data_fits  = w_data_end <= 33'(PHYS_MEM_BYTES);
    assign o_status.de_present = r_de[BIT_PRESENT];
    assign o_status.de_need_wb = !r_de[BIT_ACCESSED];
    assign o_status.te_present = r_te[BIT_PRESENT];
    assign o_status.te_need_wb = !r_te[BIT_ACCESSED] || (r_wr && !r_te[BIT_DIRTY]);
    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

// ===== src/pmau_controller.sv =====
`timescale 1ns / 1ps
`default_nettype none
module pmau_controller (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_in_valid,
    output logic                   o_in_ready,
    output logic                   o_out_valid,
    input  wire                    i_out_ready,
    input  wire [2:0]              i_in_len,
    input  wire pmau_pkg::t_status i_status,
    output pmau_pkg::t_cmd         o_cmd,
    output logic                   o_rd_valid,
    output logic [1:0]             o_result_status,
    output logic                   o_result_zero
);
    import pmau_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_DE_RD, S_DE_CHK, S_DE_WB,
        S_TE_CHK_RANGE, S_TE_RD, S_TE_CHK, S_TE_WB,
        S_DATA_CHK, S_DATA, S_DATA_WAIT, S_DONE
    } t_state;

    t_state     r_state;
    logic [1:0] r_idx;
    logic       r_rd_valid;
    logic [1:0] r_st;
    logic       r_out_valid;

    // accept the next word once the result has gone
    assign o_in_ready  = (r_state == S_IDLE) && !r_out_valid;
    assign o_out_valid = r_out_valid;
    assign o_rd_valid  = r_rd_valid;
    assign o_result_status = r_st;
    assign o_result_zero   = i_status.wr || (r_st != ST_OK);

    // command decode
    always_comb begin
        o_cmd.op  = t_OP_NONE;
        o_cmd.src = t_SRC_DATA;
        o_cmd.idx = r_idx;
        o_cmd.set_te_dirty = i_status.wr;
        unique case (r_state)
            S_IDLE:  if (i_in_valid && o_in_ready) o_cmd.op = t_OP_START;
            S_DE_RD: begin o_cmd.op = t_OP_READ_BYTE; o_cmd.src = t_SRC_DE; end
            S_DE_WB: begin o_cmd.op = t_OP_WRITE_BYTE; o_cmd.src = t_SRC_DE; end
            S_TE_RD: begin o_cmd.op = t_OP_READ_BYTE; o_cmd.src = t_SRC_TE; end
            S_TE_WB: begin o_cmd.op = t_OP_WRITE_BYTE; o_cmd.src = t_SRC_TE; end
            S_DATA:  o_cmd.op = i_status.wr ? t_OP_WRITE_BYTE : t_OP_READ_BYTE;
            S_DONE:  if (i_status.split && !i_status.second && r_st == ST_OK)
                         o_cmd.op = t_OP_NEXT_PART;
            default: ;
        endcase
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= 2'd0;
            r_rd_valid  <= 1'b0;
            r_st        <= ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_valid <= (o_cmd.op == t_OP_READ_BYTE);
            if (r_out_valid && i_out_ready)
                r_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: if (i_in_valid && o_in_ready) begin
                    r_st <= ST_OK;
                    if (i_in_len == 3'd0) r_out_valid <= 1'b1;
                    else r_state <= S_CHECK;
                end
                S_CHECK: begin
                    r_idx <= 2'd0;
                    if (!i_status.paging) r_state <= S_DATA_CHK;
                    else if (!i_status.de_fits) begin r_st <= ST_RANGE; r_state <= S_DONE; end
                    else r_state <= S_DE_RD;
                end
                S_DE_RD: begin
                    r_idx <= r_idx + 2'd1;
                    if (r_idx == 2'd3) r_state <= S_DE_CHK;
                end
                S_DE_CHK: if (!r_rd_valid) begin
                    r_idx <= 2'd0;
                    if (!i_status.de_present) begin
                        r_st <= ST_NOT_PRESENT; r_state <= S_DONE;
                    end else if (i_status.de_need_wb) r_state <= S_DE_WB;
                    else r_state <= S_TE_CHK_RANGE;
                end
                S_DE_WB: begin
                    r_idx <= r_idx + 2'd1;
                    if (r_idx == 2'd3) r_state <= S_TE_CHK_RANGE;
                end
                S_TE_CHK_RANGE: begin
                    r_idx <= 2'd0;
                    if (!i_status.te_fits) begin r_st <= ST_RANGE; r_state <= S_DONE; end
                    else r_state <= S_TE_RD;
                end
                S_TE_RD: begin
                    r_idx <= r_idx + 2'd1;
                    if (r_idx == 2'd3) r_state <= S_TE_CHK;
                end
                S_TE_CHK: if (!r_rd_valid) begin
                    r_idx <= 2'd0;
                    if (!i_status.te_present) begin
                        r_st <= ST_NOT_PRESENT; r_state <= S_DONE;
                    end else if (i_status.te_need_wb) r_state <= S_TE_WB;
                    else r_state <= S_DATA_CHK;
                end
                S_TE_WB: begin
                    r_idx <= r_idx + 2'd1;
                    if (r_idx == 2'd3) begin r_idx <= 2'd0; r_state <= S_DATA_CHK; end
                end
                S_DATA_CHK: begin
                    r_idx <= 2'd0;
                    if (!i_status.data_fits) begin r_st <= ST_RANGE; r_state <= S_DONE; end
                    else r_state <= S_DATA;
                end
                S_DATA: begin
                    r_idx <= r_idx + 2'd1;
                    if ({1'b0, r_idx} + 3'd1 == i_status.len) r_state <= S_DATA_WAIT;
                end
                S_DATA_WAIT: if (!r_rd_valid) r_state <= S_DONE;
                S_DONE: begin
                    if (i_status.split && !i_status.second && r_st == ST_OK)
                        r_state <= S_CHECK;
                    else begin
                        r_out_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== src/paged_memory_access_unit.sv =====
// paged memory access unit
// in channel (i_in): words of {opcode, virtual_address, access_length, write_data},
// packed opcode at the top, write_data at the bottom; one access of up to 4 bytes (a longer length is cut to 4).
// out channel (o_out): words of {read_data, status}, one per access.
// config port: i_cfg_we, i_cfg_index (0 paging_enable, 1 page_dir_base), i_cfg_data.
// one access at a time through a single byte-wide memory port.
// a physical access moves its len bytes one at a time; a paged part
// adds a walk of 4 entry byte reads per level plus 4 byte
// write-backs when a flag changes; a page-crossing access does two parts.
// a zero-length access answers without touching memory.
// the next word can be taken from the cycle after the result is delivered.
// the memory is not cleared: software loads it, page tables included,
// before use. reset clears the sequencer and the configuration registers.
// a stalled result holds in the output register; no new word is taken
// until it has been delivered.
`timescale 1ns / 1ps
`default_nettype none
module paged_memory_access_unit #(
    parameter int PHYS_MEM_BYTES = 65536
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire         i_cfg_index,
    input  wire [19:0]  i_cfg_data,
    pmau_stream_if.sink   i_in,
    pmau_stream_if.source o_out
);
    import pmau_pkg::*;

    logic        r_paging;
    logic [19:0] r_pdb;
    t_cmd        w_cmd;
    t_status     w_status;
    logic        w_rd_valid, w_zero;
    logic [1:0]  w_st;
    logic [31:0] w_rdata;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_paging <= 1'b0;
            r_pdb    <= 20'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_PAGING_ENABLE: r_paging <= i_cfg_data[0];
                default:           r_pdb    <= i_cfg_data;
            endcase
        end
    end

    pmau_controller u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in.valid), .o_in_ready(i_in.ready),
        .o_out_valid(o_out.valid), .i_out_ready(o_out.ready),
        .i_in_len(i_in.data[34:32]), .i_status(w_status), .o_cmd(w_cmd),
        .o_rd_valid(w_rd_valid), .o_result_status(w_st), .o_result_zero(w_zero)
    );

    pmau_datapath #(.PHYS_MEM_BYTES(PHYS_MEM_BYTES)) u_dp (
        .i_clk(i_clk), .i_paging(r_paging), .i_pdb(r_pdb),
        .i_in_wr(i_in.data[67]), .i_in_va(i_in.data[66:35]),
        .i_in_len(i_in.data[34:32]), .i_in_wdata(i_in.data[31:0]),
        .i_cmd(w_cmd), .i_rd_valid(w_rd_valid), .o_status(w_status), .o_rdata(w_rdata)
    );

    assign o_out.data = {(w_zero ? 32'd0 : w_rdata), w_st};
endmodule
`default_nettype wire

// ===== tb/sv/paged_memory_access_unit_tb.sv =====
`timescale 1ns / 1ps
module paged_memory_access_unit_tb;
    import pmau_pkg::*;

    localparam int MEM_BYTES  = 65536;
    localparam int STALL_MAX  = 3000;
    localparam int HOLD_LEN   = 400;
    localparam int SEG_ITEMS  = 150;
    localparam int SEG_COUNT  = 6;
    localparam bit OPC_READ   = 1'b0;
    localparam bit OPC_WRITE  = 1'b1;

    typedef struct {
        bit        opc;
        bit [31:0] va;
        bit [2:0]  len;
        bit [31:0] wdata;
    } t_access;

    typedef struct {
        bit [31:0] rdata;
        bit [1:0]  st;
    } t_outcome;

    // byte memory image, page walk and expected outcomes
    class access_scoreboard;
        byte unsigned mem_image [MEM_BYTES];
        bit           written [MEM_BYTES];
        bit           paging;
        bit [19:0]    dir_frame;
        t_outcome     pending_q [$];
        int           errors;
        int           st_count [3];
        bit           commit;
        bit           unwritten_hit;

        function bit fits(bit [31:0] pa, int n);
            return (longint'(pa) + n) <= MEM_BYTES;
        endfunction

        function bit [31:0] load(bit [31:0] pa, int n);
            bit [31:0] v;
            v = 0;
            for (int i = 0; i < n; i++) begin
                if (!written[pa + i]) unwritten_hit = 1;
                v |= 32'(mem_image[pa + i]) << (8 * i);
            end
            return v;
        endfunction

        function void store(bit [31:0] pa, int n, bit [31:0] v);
            if (!commit) return;
            for (int i = 0; i < n; i++) begin
                mem_image[pa + i] = v[8*i +: 8];
                written[pa + i] = 1;
            end
        endfunction

        // two-level walk with accessed and dirty updates
        function bit [1:0] walk(bit [31:0] va, bit wr, output bit [31:0] pa);
            bit [31:0] de_addr, de, te_addr, te;
            pa = 0;
            de_addr = {dir_frame, 12'h000} + {20'h0, va[31:22], 2'b00};
            if (!fits(de_addr, 4)) return ST_RANGE;
            de = load(de_addr, 4);
            if (!de[BIT_PRESENT]) return ST_NOT_PRESENT;
            if (!de[BIT_ACCESSED]) begin
                de[BIT_ACCESSED] = 1;
                store(de_addr, 4, de);
            end
            te_addr = {de[31:12], 12'h000} + {20'h0, va[21:12], 2'b00};
            if (!fits(te_addr, 4)) return ST_RANGE;
            te = load(te_addr, 4);
            if (!te[BIT_PRESENT]) return ST_NOT_PRESENT;
            if (!te[BIT_ACCESSED] || (wr && !te[BIT_DIRTY])) begin
                te[BIT_ACCESSED] = 1;
                if (wr) te[BIT_DIRTY] = 1;
                store(te_addr, 4, te);
            end
            pa = {te[31:12], va[11:0]};
            return ST_OK;
        endfunction

        function bit [1:0] data_part(bit [31:0] pa, int n, bit wr, bit [31:0] wd,
                                     output bit [31:0] rd);
            rd = 0;
            if (!fits(pa, n)) return ST_RANGE;
            if (wr) store(pa, n, wd);
            else rd = load(pa, n);
            return ST_OK;
        endfunction

        function bit [1:0] paged_part(bit [31:0] va, int n, bit wr, bit [31:0] wd,
                                      output bit [31:0] rd);
            bit [31:0] pa;
            bit [1:0]  st;
            rd = 0;
            st = walk(va, wr, pa);
            if (st != ST_OK) return st;
            return data_part(pa, n, wr, wd, rd);
        endfunction

        // expected outcome; with do_commit clear the image is left untouched
        function t_outcome predict(t_access a, bit do_commit, output bit bad);
            t_outcome  r;
            int        n, room, lo_n;
            bit [31:0] lo, hi;
            commit = do_commit;
            unwritten_hit = 0;
            r.rdata = 0;
            r.st = ST_OK;
            n = (a.len > 4) ? 4 : int'(a.len);
            if (n != 0) begin
                if (!paging) begin
                    r.st = data_part(a.va, n, a.opc, a.wdata, r.rdata);
                end else begin
                    room = 4096 - int'(a.va[11:0]);
                    if (n <= room) begin
                        r.st = paged_part(a.va, n, a.opc, a.wdata, r.rdata);
                    end else begin
                        lo_n = room;
                        hi = 0;
                        r.st = paged_part(a.va, lo_n, a.opc,
                                          a.wdata & ((32'h1 << (8 * lo_n)) - 1), lo);
                        if (r.st == ST_OK)
                            r.st = paged_part(a.va + lo_n, n - lo_n, a.opc,
                                              a.wdata >> (8 * lo_n), hi);
                        r.rdata = lo | (hi << (8 * lo_n));
                    end
                end
            end
            if (a.opc == OPC_WRITE || r.st != ST_OK) r.rdata = 0;
            bad = unwritten_hit;
            commit = 0;
            return r;
        endfunction

        function t_outcome note_access(t_access a);
            t_outcome r;
            bit       bad;
            r = predict(a, 1, bad);
            pending_q.push_back(r);
            st_count[r.st]++;
            return r;
        endfunction

        function void check_result(bit [31:0] rd, bit [1:0] st);
            t_outcome e;
            if (pending_q.size() == 0) begin
                $error("result word with nothing expected: read_data %h status %0d", rd, st);
                errors++;
                return;
            end
            e = pending_q.pop_front();
            if (rd !== e.rdata) begin
                $error("read_data expected %h actual %h", e.rdata, rd);
                errors++;
            end
            if (st !== e.st) begin
                $error("status expected %0d actual %0d", e.st, st);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic i_cfg_index = 1'b0;
    logic [19:0] i_cfg_data = '0;

    pmau_stream_if #(.WIDTH(68)) in_ch ();
    pmau_stream_if #(.WIDTH(34)) out_ch ();

    access_scoreboard sb = new();

    int        tx_idle = 0;
    int        rx_idle = 0;
    int        hold_requests = 0;
    int        hold_seen = 0;
    int        hold_left = 0;
    int        stall_cnt = 0;
    int        n_items = 0;
    int        n_splits = 0;
    bit [31:0] phys_pool [$];
    bit [31:0] virt_pool [$];

    paged_memory_access_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
    end

    // receiver ready with random stalls and an occasional long hold-off
    always @(posedge i_clk) begin
        if (hold_requests != hold_seen) begin
            hold_seen = hold_requests;
            hold_left = HOLD_LEN;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(0, 99) >= rx_idle);
        end
    end

    // result word check
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready)
            sb.check_result(out_ch.data[33:2], out_ch.data[1:0]);
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            stall_cnt <= 0;
        end else begin
            stall_cnt <= stall_cnt + 1;
            if (stall_cnt >= STALL_MAX) begin
                $display("watchdog: no word moved for %0d cycles", STALL_MAX);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    task automatic cfg_write(input logic idx, input logic [19:0] value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_PAGING_ENABLE) sb.paging = value[0];
        else sb.dir_frame = value;
    endtask

    // offer one access word and note it once taken
    task automatic send_access(input t_access a);
        t_outcome r;
        while ($urandom_range(0, 99) < tx_idle) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data <= {a.opc, a.va, a.len, a.wdata};
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        r = sb.note_access(a);
        n_items++;
        if (sb.paging && a.len != 0 && (int'(a.va[11:0]) + ((a.len > 4) ? 4 : a.len)) > 4096)
            n_splits++;
        if (a.opc == OPC_WRITE && r.st == ST_OK && a.len != 0) begin
            if (sb.paging) virt_pool.push_back(a.va);
            else phys_pool.push_back(a.va);
        end
    endtask

    task automatic send_fields(input bit opc, input bit [31:0] va, input bit [2:0] len,
                               input bit [31:0] wd);
        t_access a;
        a.opc = opc;
        a.va = va;
        a.len = len;
        a.wdata = wd;
        send_access(a);
    endtask

    // wait for every result, then let the block settle
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    function automatic bit [31:0] pick_address(bit paged);
        bit [31:0] va;
        int        sel;
        int        tsel;
        bit [9:0]  tbl_set [6] = '{10'h000, 10'h001, 10'h002, 10'h003, 10'h3fe, 10'h3ff};
        bit [9:0]  dir_set [5] = '{10'h000, 10'h001, 10'h002, 10'h003, 10'h3ff};
        sel = $urandom_range(0, 99);
        if (paged) begin
            if (sel < 45 && virt_pool.size() != 0)
                return virt_pool[$urandom_range(0, virt_pool.size() - 1)]
                       + $urandom_range(0, 3) - 1;
            tsel = $urandom_range(0, 5);
            va[31:22] = dir_set[$urandom_range(0, 4)];
            va[21:12] = tbl_set[tsel];
            va[11:0] = ($urandom_range(0, 3) == 0) ? 12'hffc + $urandom_range(0, 3)
                                                   : 12'($urandom);
            return va;
        end
        if (sel < 45 && phys_pool.size() != 0)
            return phys_pool[$urandom_range(0, phys_pool.size() - 1)]
                   + $urandom_range(0, 3) - 1;
        if (sel < 55)
            return ($urandom_range(0, 1)) ? 32'($urandom) : 32'(MEM_BYTES - $urandom_range(1, 6));
        // scratch frame or data frames, never the page tables
        if ($urandom_range(0, 2) == 0) va = 32'($urandom_range(0, 4095));
        else va = {16'h0, 4'($urandom_range(5, 15)), 12'($urandom)};
        return va;
    endfunction

    // random access that never reads a byte that was not stored first
    task automatic send_random();
        t_access  a;
        t_outcome r;
        bit       bad;
        int       tries;
        tries = 0;
        do begin
            a.opc = (tries > 40) ? OPC_WRITE : 1'($urandom_range(0, 1));
            a.va = pick_address(sb.paging);
            a.len = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7))
                                                : 3'($urandom_range(1, 4));
            a.wdata = $urandom;
            r = sb.predict(a, 0, bad);
            tries++;
        end while (bad);
        send_access(a);
    endtask

    initial begin
        bit [31:0] tbl_frames [3] = '{32'h2000, 32'h3000, 32'h4000};
        bit [9:0]  tbl_set [6] = '{10'h000, 10'h001, 10'h002, 10'h003, 10'h3fe, 10'h3ff};
        bit [31:0] flag_set [3] = '{32'h01, 32'h21, 32'h61};
        bit [31:0] entry;
        int        seg;

        // reset
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        cfg_write(CFG_PAGING_ENABLE, 20'd0);
        cfg_write(CFG_PAGE_DIR_BASE, 20'd0);

        // page directory at frame 1 and its tables, loaded physically
        send_fields(OPC_WRITE, 32'h1000, 3'd4, 32'h0000_2001);
        send_fields(OPC_WRITE, 32'h1004, 3'd4, 32'h0000_3021);
        send_fields(OPC_WRITE, 32'h1008, 3'd4, 32'h0000_0000);
        send_fields(OPC_WRITE, 32'h100c, 3'd4, 32'hffff_f001);
        send_fields(OPC_WRITE, 32'h1ffc, 3'd4, 32'h0000_4001);
        for (int t = 0; t < 3; t++) begin
            for (int k = 0; k < 6; k++) begin
                if (t == 0 && k == 2) entry = 32'h0;
                else if (t == 1 && k == 3) entry = 32'h0010_0001;
                else entry = {20'(5 + ((t * 7 + k) % 11)), 12'h0} | flag_set[k % 3];
                send_fields(OPC_WRITE, tbl_frames[t] + {20'h0, tbl_set[k], 2'b00}, 3'd4,
                            entry);
            end
        end

        // physical extremes, zero length and saturated length
        send_fields(OPC_WRITE, 32'h0000_fffc, 3'd4, 32'hffff_ffff);
        send_fields(OPC_READ, 32'h0000_fffc, 3'd4, 32'h0);
        send_fields(OPC_READ, 32'h0000_fffe, 3'd4, 32'h0);
        send_fields(OPC_WRITE, 32'hffff_ffff, 3'd1, 32'h0000_00a5);
        send_fields(OPC_READ, 32'h0000_0000, 3'd0, 32'hffff_ffff);
        send_fields(OPC_READ, 32'h0000_1000, 3'd7, 32'h0);
        drain();

        // paged: faults, partial split write, address wrap
        cfg_write(CFG_PAGE_DIR_BASE, 20'd1);
        cfg_write(CFG_PAGING_ENABLE, 20'd1);
        send_fields(OPC_WRITE, 32'h0000_1ffe, 3'd4, 32'hcafe_f00d);
        send_fields(OPC_READ, 32'h0000_1ffe, 3'd2, 32'h0);
        send_fields(OPC_READ, 32'h0080_0000, 3'd1, 32'h0);
        send_fields(OPC_READ, 32'h00c0_0000, 3'd1, 32'h0);
        send_fields(OPC_WRITE, 32'h0040_3000, 3'd2, 32'h1234_5678);
        send_fields(OPC_WRITE, 32'hffff_fffe, 3'd4, 32'h8765_4321);
        send_fields(OPC_READ, 32'hffff_fffe, 3'd5, 32'h0);
        drain();

        // directory placed past the end of memory
        cfg_write(CFG_PAGE_DIR_BASE, 20'hfffff);
        for (int i = 0; i < 6; i++) send_random();
        drain();
        cfg_write(CFG_PAGE_DIR_BASE, 20'd1);

        // random segments: paging on and off, three idling patterns
        for (seg = 0; seg < SEG_COUNT; seg++) begin
            cfg_write(CFG_PAGING_ENABLE, 20'(seg % 2 == 0));
            case (seg / 2)
                0: begin
                    tx_idle = 37;
                    rx_idle = 87;
                end
                1: begin
                    tx_idle = 87;
                    rx_idle = 37;
                end
                default: begin
                    tx_idle = 0;
                    rx_idle = 0;
                end
            endcase
            if (seg == 4) hold_requests++;
            for (int i = 0; i < SEG_ITEMS; i++) send_random();
            drain();
        end

        if (sb.pending_q.size() != 0) begin
            $error("%0d results never arrived", sb.pending_q.size());
            sb.errors++;
        end
        $display("covered %0d accesses (%0d page-crossing): %0d ok, %0d not present,",
                 n_items, n_splits, sb.st_count[0], sb.st_count[1]);
        $display("%0d out of range; paging on and off, directory base 0, 1 and top frame,",
                 sb.st_count[2]);
        $display("stalls on both sides");
        if (sb.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule

// ===== files.f =====
src/pmau_pkg.sv
src/pmau_stream_if.sv
src/pmau_datapath.sv
src/pmau_controller.sv
src/paged_memory_access_unit.sv
tb/sv/paged_memory_access_unit_tb.sv
